FILE: rtl/core/uicf_pkg.sv
package uicf_pkg;

    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_C2    = 8'hC2;
    localparam logic [7:0] BYTE_A0    = 8'hA0;
    localparam logic [7:0] BYTE_AD    = 8'hAD;
    localparam logic [7:0] BYTE_E2    = 8'hE2;
    localparam logic [7:0] BYTE_80    = 8'h80;
    localparam logic [7:0] BYTE_8B    = 8'h8B;
    localparam logic [7:0] BYTE_A8    = 8'hA8;
    localparam logic [7:0] BYTE_A9    = 8'hA9;
    localparam logic [7:0] BYTE_81    = 8'h81;
    localparam logic [7:0] BYTE_EF    = 8'hEF;
    localparam logic [7:0] BYTE_BB    = 8'hBB;
    localparam logic [7:0] BYTE_BF    = 8'hBF;

    localparam int MAX_OUT = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       out_last;
    } out_beat_t;

    // results caused by one input beat; cnt is 1..3
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [1:0]              cnt;
        logic                    present;
        logic                    last;
    } bundle_t;

endpackage

FILE: rtl/core/utf8_invisible_char_filter.sv
// An accepted input beat's results pass through a registered bundle queue.
// Throughput: one input beat per cycle while the queue has room; an input beat
// causing k results (k up to 3) gives k result beats via a 4-entry bundle queue.
// Reset: aresetn synchronous, active low; clears the prefix state, the queue
// and the result index. No clearing pass; ready in the first cycle after reset.
module utf8_invisible_char_filter import uicf_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic    push_valid, push_ready, pop_valid, pop_ready;
    bundle_t push_data, pop_data;

    uicf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    uicf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    uicf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: rtl/core/uicf_front.sv
module uicf_front import uicf_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_beat_t s_data,
    output logic     push_valid,
    input  logic     push_ready,
    output bundle_t  push_data
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_C2     = 3'd1,
        ST_E2     = 3'd2,
        ST_E2_80  = 3'd3,
        ST_E2_81  = 3'd4,
        ST_EF     = 3'd5,
        ST_EF_BB  = 3'd6
    } state_t;

    state_t state_reg, state_next;

    logic [MAX_OUT-1:0][7:0] bytes;
    logic [1:0]              n;
    logic                    fail;
    state_t                  st;
    logic [7:0]              b;

    always_comb begin
        b          = s_data.in_byte;
        bytes      = '0;
        n          = 2'd0;
        fail       = 1'b0;
        st         = state_reg;
        state_next = ST_IDLE;

        unique case (state_reg)
            ST_C2: begin
                if (b == BYTE_A0) begin
                    bytes[n] = BYTE_SPACE;
                    n        = n + 2'd1;
                end else if (b != BYTE_AD) begin
                    fail = 1'b1;
                end
            end
            ST_E2: begin
                if (b == BYTE_80) begin
                    state_next = ST_E2_80;
                end else if (b == BYTE_81) begin
                    state_next = ST_E2_81;
                end else begin
                    fail = 1'b1;
                end
            end
            ST_E2_80: begin
                if (!(b == BYTE_8B || b == BYTE_A8 || b == BYTE_A9)) begin
                    fail = 1'b1;
                end
            end
            ST_E2_81: begin
                if (b != BYTE_A0) begin
                    fail = 1'b1;
                end
            end
            ST_EF: begin
                if (b == BYTE_BB) begin
                    state_next = ST_EF_BB;
                end else begin
                    fail = 1'b1;
                end
            end
            ST_EF_BB: begin
                if (b != BYTE_BF) begin
                    fail = 1'b1;
                end
            end
            default: begin
                st   = ST_IDLE;
                fail = 1'b1;
            end
        endcase

        if (fail) begin
            // flush held prefix, then rescan current byte from idle
            case (st)
                ST_C2: begin
                    bytes[n] = BYTE_C2;
                    n        = n + 2'd1;
                end
                ST_E2: begin
                    bytes[n] = BYTE_E2;
                    n        = n + 2'd1;
                end
                ST_E2_80, ST_E2_81: begin
                    bytes[n] = BYTE_E2;
                    n        = n + 2'd1;
                    bytes[n] = (st == ST_E2_80) ? BYTE_80 : BYTE_81;
                    n        = n + 2'd1;
                end
                ST_EF: begin
                    bytes[n] = BYTE_EF;
                    n        = n + 2'd1;
                end
                ST_EF_BB: begin
                    bytes[n] = BYTE_EF;
                    n        = n + 2'd1;
                    bytes[n] = BYTE_BB;
                    n        = n + 2'd1;
                end
                default: ;
            endcase
            state_next = ST_IDLE;
            if (b < BYTE_SPACE) begin
                if (b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR) begin
                    bytes[n] = b;
                    n        = n + 2'd1;
                end
            end else if (b == BYTE_C2) begin
                state_next = ST_C2;
            end else if (b == BYTE_E2) begin
                state_next = ST_E2;
            end else if (b == BYTE_EF) begin
                state_next = ST_EF;
            end else begin
                bytes[n] = b;
                n        = n + 2'd1;
            end
        end

        if (s_data.in_last) begin
            // only single-byte prefixes can remain after a rescan
            case (state_next)
                ST_C2: begin
                    bytes[n] = BYTE_C2;
                    n        = n + 2'd1;
                end
                ST_E2, ST_E2_80, ST_E2_81: begin
                    bytes[n] = BYTE_E2;
                    n        = n + 2'd1;
                    if (state_next != ST_E2) begin
                        bytes[n] = (state_next == ST_E2_80) ? BYTE_80 : BYTE_81;
                        n        = n + 2'd1;
                    end
                end
                ST_EF, ST_EF_BB: begin
                    bytes[n] = BYTE_EF;
                    n        = n + 2'd1;
                    if (state_next == ST_EF_BB) begin
                        bytes[n] = BYTE_BB;
                        n        = n + 2'd1;
                    end
                end
                default: ;
            endcase
            state_next = ST_IDLE;
        end
    end

    assign s_ready            = push_ready;
    assign push_valid         = s_valid && ((n != 2'd0) || s_data.in_last);
    assign push_data.bytes    = bytes;
    assign push_data.cnt      = (n == 2'd0) ? 2'd1 : n;
    assign push_data.present  = (n != 2'd0);
    assign push_data.last     = s_data.in_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else if (s_valid && s_ready) begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/uicf_queue.sv
module uicf_queue import uicf_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push_valid,
    output logic    push_ready,
    input  bundle_t push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output bundle_t pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bundle_t         slot_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/core/uicf_back.sv
module uicf_back import uicf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  bundle_t   pop_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    logic [1:0] idx_reg;
    logic       at_end;

    assign at_end              = (idx_reg == pop_data.cnt - 2'd1);
    assign m_valid             = pop_valid;
    assign m_data.out_byte     = pop_data.bytes[idx_reg];
    assign m_data.byte_present = pop_data.present;
    assign m_data.out_last     = pop_data.last && at_end;
    assign pop_ready           = m_ready && at_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= 2'd0;
        end else if (m_valid && m_ready) begin
            idx_reg <= at_end ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import uicf_pkg::*;

    typedef enum logic [2:0] {
        PFX_IDLE,
        PFX_C2,
        PFX_E2,
        PFX_E2_80,
        PFX_E2_81,
        PFX_EF,
        PFX_EF_BB
    } prefix_t;

    class filter_checker;
        out_beat_t expected_beats[$];
        out_beat_t fresh[$];
        prefix_t   held;
        int        errors;

        function new();
            held   = PFX_IDLE;
            errors = 0;
        endfunction

        function void emit(logic [7:0] b);
            out_beat_t r;
            if (fresh.size() < MAX_OUT) begin
                r.out_byte     = b;
                r.byte_present = 1'b1;
                r.out_last     = 1'b0;
                fresh.push_back(r);
            end
        endfunction

        function void flush_held(prefix_t p);
            case (p)
                PFX_C2:    emit(BYTE_C2);
                PFX_E2:    emit(BYTE_E2);
                PFX_E2_80: begin
                    emit(BYTE_E2);
                    emit(BYTE_80);
                end
                PFX_E2_81: begin
                    emit(BYTE_E2);
                    emit(BYTE_81);
                end
                PFX_EF:    emit(BYTE_EF);
                PFX_EF_BB: begin
                    emit(BYTE_EF);
                    emit(BYTE_BB);
                end
                default: ;
            endcase
        endfunction

        function prefix_t start_byte(logic [7:0] b);
            if (b < BYTE_SPACE) begin
                if (b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR) emit(b);
                return PFX_IDLE;
            end
            if (b == BYTE_C2) return PFX_C2;
            if (b == BYTE_E2) return PFX_E2;
            if (b == BYTE_EF) return PFX_EF;
            emit(b);
            return PFX_IDLE;
        endfunction

        function void note_beat(in_beat_t beat);
            prefix_t    nxt;
            logic       miss;
            logic [7:0] b;
            out_beat_t  r;
            fresh.delete();
            b    = beat.in_byte;
            miss = 1'b0;
            nxt  = PFX_IDLE;
            case (held)
                PFX_C2: begin
                    if (b == BYTE_A0) emit(BYTE_SPACE);
                    else if (b != BYTE_AD) miss = 1'b1;
                end
                PFX_E2: begin
                    if (b == BYTE_80) nxt = PFX_E2_80;
                    else if (b == BYTE_81) nxt = PFX_E2_81;
                    else miss = 1'b1;
                end
                PFX_E2_80: begin
                    if (b != BYTE_8B && b != BYTE_A8 && b != BYTE_A9) miss = 1'b1;
                end
                PFX_E2_81: begin
                    if (b != BYTE_A0) miss = 1'b1;
                end
                PFX_EF: begin
                    if (b == BYTE_BB) nxt = PFX_EF_BB;
                    else miss = 1'b1;
                end
                PFX_EF_BB: begin
                    if (b != BYTE_BF) miss = 1'b1;
                end
                default: miss = 1'b1;
            endcase
            if (miss) begin
                flush_held(held);
                nxt = start_byte(b);
            end
            if (beat.in_last) begin
                flush_held(nxt);
                nxt = PFX_IDLE;
                if (fresh.size() == 0) begin
                    r          = '0;
                    r.out_last = 1'b1;
                end else begin
                    r          = fresh.pop_back();
                    r.out_last = 1'b1;
                end
                fresh.push_back(r);
            end
            held = nxt;
            foreach (fresh[i]) expected_beats.push_back(fresh[i]);
        endfunction

        function void check_beat(out_beat_t got);
            out_beat_t want;
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_beats.pop_front();
            if (got.out_byte !== want.out_byte) begin
                errors++;
                $display("%0t: out_byte expected %h actual %h",
                         $time, want.out_byte, got.out_byte);
            end
            if (got.byte_present !== want.byte_present) begin
                errors++;
                $display("%0t: byte_present expected %b actual %b",
                         $time, want.byte_present, got.byte_present);
            end
            if (got.out_last !== want.out_last) begin
                errors++;
                $display("%0t: out_last expected %b actual %b",
                         $time, want.out_last, got.out_last);
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int IDLE_PCT       = 29;
    localparam int TARGET_BYTES   = 300;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    in_beat_t  s_data  = '0;
    logic      m_ready = 1'b0;
    logic      s_ready;
    logic      m_valid;
    out_beat_t m_data;

    filter_checker sb;
    bit         src_idle = 1'b1;
    bit         snk_idle = 1'b1;
    int         quiet_cycles = 0;
    logic [7:0] text_q[$];

    always #5 aclk = ~aclk;

    utf8_invisible_char_filter u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always @(negedge aclk) begin
        m_ready <= !snk_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_beat(s_data);
            if (m_valid && m_ready) sb.check_beat(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic last);
        in_beat_t beat;
        beat.in_byte = b;
        beat.in_last = last;
        @(negedge aclk);
        while (src_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
    endtask

    // hold off the sender until every pending result beat is out
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [23:0] seq_bytes(int idx);
        case (idx)
            0:       return {BYTE_C2, BYTE_A0, 8'h00};
            1:       return {BYTE_C2, BYTE_AD, 8'h00};
            2:       return {BYTE_E2, BYTE_80, BYTE_8B};
            3:       return {BYTE_E2, BYTE_80, BYTE_A8};
            4:       return {BYTE_E2, BYTE_80, BYTE_A9};
            5:       return {BYTE_E2, BYTE_81, BYTE_A0};
            default: return {BYTE_EF, BYTE_BB, BYTE_BF};
        endcase
    endfunction

    function automatic logic [7:0] near_miss_byte();
        case ($urandom_range(11))
            0:       return BYTE_A0;
            1:       return BYTE_AD;
            2:       return BYTE_80;
            3:       return BYTE_81;
            4:       return BYTE_8B;
            5:       return BYTE_A8;
            6:       return BYTE_A9;
            7:       return BYTE_BB;
            8:       return BYTE_BF;
            9:       return BYTE_C2;
            10:      return BYTE_E2;
            default: return BYTE_EF;
        endcase
    endfunction

    task automatic add_token();
        int          pick;
        int          idx;
        int          n;
        logic [23:0] s;
        pick = $urandom_range(99);
        idx  = $urandom_range(6);
        s    = seq_bytes(idx);
        n    = (idx < 2) ? 2 : 3;
        if (pick < 50) begin
            for (int i = 0; i < n; i++) text_q.push_back(s[23 - 8 * i -: 8]);
        end else if (pick < 70) begin
            // broken sequence: truncated prefix, then a likely wrong byte
            n = $urandom_range(n - 1, 1);
            for (int i = 0; i < n; i++) text_q.push_back(s[23 - 8 * i -: 8]);
            if ($urandom_range(1)) text_q.push_back(near_miss_byte());
            else text_q.push_back(8'($urandom_range(255)));
        end else if (pick < 85) begin
            text_q.push_back(8'($urandom_range(8'h1F)));
        end else begin
            text_q.push_back(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int sent;
        int strings;
        int tokens;
        sb = new();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        text_q = '{BYTE_C2, BYTE_A0, BYTE_C2, BYTE_AD, 8'h00, BYTE_TAB, BYTE_LF,
                   BYTE_CR, 8'h1F, 8'hFF};
        send_text();
        text_q = '{BYTE_E2, BYTE_80, BYTE_8B, BYTE_E2, BYTE_81, BYTE_A0,
                   BYTE_EF, BYTE_BB, BYTE_BF};
        send_text();
        text_q = '{BYTE_E2, BYTE_80, 8'h41};
        send_text();
        text_q = '{BYTE_EF, BYTE_BB};
        send_text();
        text_q = '{BYTE_C2};
        send_text();
        drain();

        sent    = 0;
        strings = 0;
        while (sent < TARGET_BYTES) begin
            src_idle = (strings < 10) || (strings > 30);
            snk_idle = src_idle;
            if (strings == 45) drain();
            text_q.delete();
            tokens = $urandom_range(8, 1);
            repeat (tokens) add_token();
            send_text();
            sent += text_q.size();
            strings++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
